// ===== src/mcvt_pkg.sv =====
package mcvt_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [4:0] NUM_CHANNELS_V = 5'(NUM_CHANNELS);

    localparam logic [3:0] CC_STATUS_HI = 4'hB;
    localparam logic [6:0] VOL_CTRL     = 7'd7;
    localparam logic [6:0] VOL_RESET    = 7'd100;
    localparam logic [6:0] MIDI_MAX     = 7'd127;
    localparam logic [6:0] MIDI_MIN     = 7'd1;

    localparam logic KIND_CC     = 1'b0;
    localparam logic KIND_VOLUME = 1'b1;

    // x/127 for x <= 12700: (x * 16514) >> 21
    localparam logic [14:0] RECIP_127 = 15'd16514;
    localparam int          SHIFT_127 = 21;
    // x/100 for x <= 16383: (x * 5243) >> 19
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          SHIFT_100 = 19;

    typedef enum logic [1:0] {
        REQ_RX_BYTE = 2'd0,
        REQ_SET     = 2'd1,
        REQ_GET     = 2'd2
    } t_req_e;

    typedef struct packed {
        logic       en;
        logic [3:0] ch;
        logic [6:0] vol;
    } t_vol_wr;

    // controller value 0..127 -> percent 0..100
    function automatic logic [6:0] midi_to_percent(input logic [6:0] v);
        logic [13:0] y;
        logic [28:0] p;
        y = (14'(v) << 6) + (14'(v) << 5) + (14'(v) << 2);
        p = 29'(y) * 29'(RECIP_127);
        return p[SHIFT_127 +: 7];
    endfunction

    // percent 0..127 -> controller value clamped to 1..127
    function automatic logic [6:0] percent_to_midi(input logic [6:0] avg);
        logic [13:0] y;
        logic [26:0] p;
        logic [7:0]  q;
        y = (14'(avg) << 7) - 14'(avg);
        p = 27'(y) * 27'(RECIP_100);
        q = p[SHIFT_100 +: 8];
        if (q == 8'd0) begin
            return MIDI_MIN;
        end else if (q > {1'b0, MIDI_MAX}) begin
            return MIDI_MAX;
        end
        return q[6:0];
    endfunction

endpackage

// ===== src/mcvt_parser.sv =====
module mcvt_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_valid,
    input  logic [7:0]        i_byte,
    output mcvt_pkg::t_vol_wr o_vol_wr
);
    import mcvt_pkg::*;

    logic [7:0] r_running_status;
    logic       r_data_count;
    logic [6:0] r_first_byte;
    logic       w_is_cc;

    assign w_is_cc = (r_running_status[7:4] == CC_STATUS_HI);

    always_comb begin
        o_vol_wr.en  = i_byte_valid && !i_byte[7] && w_is_cc && r_data_count
                       && (r_first_byte == VOL_CTRL);
        o_vol_wr.ch  = r_running_status[3:0];
        o_vol_wr.vol = midi_to_percent(i_byte[6:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_status <= 8'd0;
            r_data_count     <= 1'b0;
            r_first_byte     <= 7'd0;
        end else if (i_byte_valid) begin
            if (i_byte[7]) begin
                r_running_status <= i_byte;
                r_data_count     <= 1'b0;
            end else if (w_is_cc) begin
                if (!r_data_count) begin
                    r_first_byte <= i_byte[6:0];
                    r_data_count <= 1'b1;
                end else begin
                    r_data_count <= 1'b0;
                end
            end
        end
    end

    a_count_under_cc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_count |-> r_running_status[7:4] == CC_STATUS_HI)
        else $error("data byte pending without control-change status");

    a_status_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte_valid && i_byte[7] |=> !r_data_count && r_running_status == $past(i_byte))
        else $error("status byte not taken as running status");

    a_write_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vol_wr.en |=> !r_data_count)
        else $error("data count not cleared after complete pair");

endmodule

// ===== src/midi_channel_volume_tracker.sv =====
// Tracks a percent volume per MIDI channel (reset to 100) from received control-change
// bytes and from set/get requests. One item is accepted per cycle unless the input
// register is stalled. An accepted item waits in the input register until it advances, and
// its result is then loaded into the result register, which drives o_valid. Received
// bytes never produce a result. Throughput drops only while the result register is held
// by a deasserted i_ready.
module midi_channel_volume_tracker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_rx_byte,
    input  logic [3:0] i_channel,
    input  logic [6:0] i_left_level,
    input  logic [6:0] i_right_level,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_result_kind,
    output logic [7:0] o_msg_status,
    output logic [6:0] o_msg_controller,
    output logic [6:0] o_msg_value,
    output logic [6:0] o_volume_percent
);
    import mcvt_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_req;
    logic [7:0] r_byte;
    logic [3:0] r_ch;
    logic [6:0] r_left;
    logic [6:0] r_right;

    logic       r_out_valid;
    logic       r_kind;
    logic [7:0] r_status;
    logic [6:0] r_ctrl;
    logic [6:0] r_value;
    logic [6:0] r_pct;

    logic [6:0] r_vol [NUM_CHANNELS];

    logic                w_advance;
    logic                w_ch_ok;
    logic [CH_IDX_W-1:0] w_ch_idx;
    logic [6:0]          w_rd_vol;
    logic [7:0]          w_sum;
    logic [6:0]          w_avg;
    logic                w_has_result;
    logic                w_set_wr;
    logic                w_byte_valid;
    t_vol_wr             w_cc_wr;
    logic                w_cc_ok;
    logic [CH_IDX_W-1:0] w_cc_idx;

    assign w_ch_ok  = {1'b0, r_ch} < NUM_CHANNELS_V;
    assign w_ch_idx = r_ch[CH_IDX_W-1:0];
    assign w_rd_vol = r_vol[w_ch_idx];
    assign w_sum    = {1'b0, r_left} + {1'b0, r_right};
    assign w_avg    = w_sum[7:1];

    always_comb begin
        w_has_result = 1'b0;
        w_set_wr     = 1'b0;
        w_byte_valid = 1'b0;
        case (r_req)
            REQ_RX_BYTE: w_byte_valid = 1'b1;
            REQ_SET: begin
                w_has_result = w_ch_ok;
                w_set_wr     = w_ch_ok;
            end
            REQ_GET: w_has_result = w_ch_ok;
            default: ;
        endcase
    end

    assign w_advance = r_in_valid && (!w_has_result || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    mcvt_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_advance && w_byte_valid),
        .i_byte       (r_byte),
        .o_vol_wr     (w_cc_wr)
    );

    assign w_cc_ok  = {1'b0, w_cc_wr.ch} < NUM_CHANNELS_V;
    assign w_cc_idx = w_cc_wr.ch[CH_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_req   <= i_req_type;
            r_byte  <= i_rx_byte;
            r_ch    <= i_channel;
            r_left  <= i_left_level;
            r_right <= i_right_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_vol[i] <= VOL_RESET;
            end
        end else if (w_advance && w_set_wr) begin
            r_vol[w_ch_idx] <= w_avg;
        end else if (w_cc_wr.en && w_cc_ok) begin
            r_vol[w_cc_idx] <= w_cc_wr.vol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_has_result) begin
            if (r_req == REQ_SET) begin
                r_kind   <= KIND_CC;
                r_status <= {CC_STATUS_HI, r_ch};
                r_ctrl   <= VOL_CTRL;
                r_value  <= percent_to_midi(w_avg);
                r_pct    <= w_avg;
            end else begin
                r_kind   <= KIND_VOLUME;
                r_status <= 8'd0;
                r_ctrl   <= 7'd0;
                r_value  <= 7'd0;
                r_pct    <= w_rd_vol;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_msg_status     = r_status;
    assign o_msg_controller = r_ctrl;
    assign o_msg_value      = r_value;
    assign o_volume_percent = r_pct;

    a_set_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_req == REQ_SET && w_ch_ok
        |=> o_valid && o_result_kind == KIND_CC && o_volume_percent == $past(w_avg))
        else $error("set item did not produce its message");

    a_get_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_req == REQ_GET && w_ch_ok
        |=> o_valid && o_result_kind == KIND_VOLUME && o_volume_percent == $past(w_rd_vol))
        else $error("get item did not return stored volume");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !w_has_result && !(r_out_valid && !i_ready) |=> !o_valid)
        else $error("result produced by an item that has none");

    a_cc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_CC
        |-> o_msg_value != 7'd0 && o_msg_controller == VOL_CTRL
            && o_msg_status[7:4] == CC_STATUS_HI)
        else $error("malformed control-change message");

endmodule

// ===== tb/midi_channel_volume_tracker_tb.sv =====
module midi_channel_volume_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcvt_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1750;
    localparam int QUIET_TAIL   = 200;

    typedef struct packed {
        logic       kind;
        logic [7:0] status;
        logic [6:0] controller;
        logic [6:0] value;
        logic [6:0] percent;
    } t_vol_result;

    class volume_scoreboard;
        logic [7:0]  run_status;
        logic        have_first;
        logic [6:0]  first_byte;
        logic [6:0]  chan_vol [16];
        t_vol_result pending_results [$];
        int          errors;

        function new();
            run_status = '0;
            have_first = 1'b0;
            first_byte = '0;
            foreach (chan_vol[i]) chan_vol[i] = VOL_RESET;
            errors = 0;
        endfunction

        function void apply_request(logic [1:0] req, logic [7:0] rx, logic [3:0] ch,
                                    logic [6:0] left, logic [6:0] right);
            t_vol_result r;
            int          sum_avg;
            int          scaled;
            logic [3:0]  cc_ch;
            r = '0;
            if (req == REQ_RX_BYTE) begin
                if (rx[7]) begin
                    run_status = rx;
                    have_first = 1'b0;
                end else if (run_status[7:4] == CC_STATUS_HI) begin
                    if (!have_first) begin
                        first_byte = rx[6:0];
                        have_first = 1'b1;
                    end else begin
                        have_first = 1'b0;
                        cc_ch = run_status[3:0];
                        if (first_byte == VOL_CTRL && int'(cc_ch) < NUM_CHANNELS)
                            chan_vol[cc_ch] = 7'((int'(rx[6:0]) * 100) / 127);
                    end
                end
            end else if (req == REQ_SET && int'(ch) < NUM_CHANNELS) begin
                sum_avg = (int'(left) + int'(right)) / 2;
                scaled  = sum_avg * 127 / 100;
                if (scaled < int'(MIDI_MIN)) scaled = int'(MIDI_MIN);
                else if (scaled > int'(MIDI_MAX)) scaled = int'(MIDI_MAX);
                chan_vol[ch]  = 7'(sum_avg);
                r.kind        = KIND_CC;
                r.status      = {CC_STATUS_HI, ch};
                r.controller  = VOL_CTRL;
                r.value       = 7'(scaled);
                r.percent     = 7'(sum_avg);
                pending_results.push_back(r);
            end else if (req == REQ_GET && int'(ch) < NUM_CHANNELS) begin
                r.kind    = KIND_VOLUME;
                r.percent = chan_vol[ch];
                pending_results.push_back(r);
            end
        endfunction

        task report(string msg);
            $display("%0t: ERROR: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d, want %0d", name, got, want));
        endtask

        task check_result(t_vol_result got);
            t_vol_result want;
            if (pending_results.size() == 0) begin
                report("result with nothing outstanding");
            end else begin
                want = pending_results.pop_front();
                compare_field("result_kind", got.kind, want.kind);
                compare_field("msg_status", got.status, want.status);
                compare_field("msg_controller", got.controller, want.controller);
                compare_field("msg_value", got.value, want.value);
                compare_field("volume_percent", got.percent, want.percent);
            end
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_req_type = '0;
    logic [7:0] i_rx_byte = '0;
    logic [3:0] i_channel = '0;
    logic [6:0] i_left_level = '0;
    logic [6:0] i_right_level = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_result_kind;
    logic [7:0] o_msg_status;
    logic [6:0] o_msg_controller;
    logic [6:0] o_msg_value;
    logic [6:0] o_volume_percent;

    volume_scoreboard sb;
    bit idle_on = 1'b1;
    int sent_count = 0;

    midi_channel_volume_tracker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_rx_byte        (i_rx_byte),
        .i_channel        (i_channel),
        .i_left_level     (i_left_level),
        .i_right_level    (i_right_level),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_kind    (o_result_kind),
        .o_msg_status     (o_msg_status),
        .o_msg_controller (o_msg_controller),
        .o_msg_value      (o_msg_value),
        .o_volume_percent (o_volume_percent)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task send_item(logic [1:0] req, logic [7:0] rx, logic [3:0] ch,
                   logic [6:0] left, logic [6:0] right);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_rx_byte     <= rx;
        i_channel     <= ch;
        i_left_level  <= left;
        i_right_level <= right;
        do @(posedge i_clk); while (!o_ready);
        sb.apply_request(req, rx, ch, left, right);
        if (req != REQ_UNUSED) sent_count++;
        @(negedge i_clk);
    endtask

    task send_byte(logic [7:0] rx);
        send_item(REQ_RX_BYTE, rx, 4'($urandom), 7'($urandom), 7'($urandom));
    endtask

    task send_set(logic [3:0] ch, logic [6:0] left, logic [6:0] right);
        send_item(REQ_SET, 8'($urandom), ch, left, right);
    endtask

    task send_get(logic [3:0] ch);
        send_item(REQ_GET, 8'($urandom), ch, 7'($urandom), 7'($urandom));
    endtask

    function automatic logic [6:0] pick_level();
        return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, 100));
    endfunction

    // output side: random stall bursts until the quiet tail
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (idle_on && stall == 0 && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 14);
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_result_kind, o_msg_status, o_msg_controller,
                             o_msg_value, o_volume_percent});
    end

    initial begin
        #5_000_000;
        $display("midi_channel_volume_tracker_tb: FAIL");
        $finish;
    end

    initial begin
        logic [3:0] ch;
        logic [6:0] ctrl;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed
        send_get(4'd15);
        send_set(4'd0, 7'd0, 7'd0);
        send_set(4'd15, 7'd100, 7'd100);
        send_set(4'd3, 7'd127, 7'd127);
        send_set(4'd5, 7'd1, 7'd0);
        send_get(4'd3);
        send_byte({CC_STATUS_HI, 4'd5});
        send_byte({1'b0, VOL_CTRL});
        send_byte(8'h7F);
        send_get(4'd5);
        send_byte({1'b0, VOL_CTRL});
        send_byte(8'h00);
        send_get(4'd5);
        send_byte(8'h0A);
        send_byte(8'h40);
        send_get(4'd5);
        send_byte(8'h90);
        send_byte({1'b0, VOL_CTRL});
        send_byte(8'h50);
        send_byte({CC_STATUS_HI, 4'd15});
        send_byte({1'b0, VOL_CTRL});
        send_byte({CC_STATUS_HI, 4'd15});
        send_byte({1'b0, VOL_CTRL});
        send_byte(8'h40);
        send_get(4'd15);
        send_item(REQ_UNUSED, 8'hFF, 4'hF, 7'h7F, 7'h7F);
        send_byte(8'hFF);

        // random
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            idle_on = (sent_count < RANDOM_ITEMS - QUIET_TAIL);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: begin
                    ch   = 4'($urandom);
                    ctrl = ($urandom_range(0, 3) != 0) ? VOL_CTRL : 7'($urandom);
                    if ($urandom_range(0, 3) != 0) send_byte({CC_STATUS_HI, ch});
                    send_byte({1'b0, ctrl});
                    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(128, 255)));
                    send_byte({1'b0, 7'($urandom)});
                    if ($urandom_range(0, 1) == 0) send_get(ch);
                end
                7, 8, 9, 10: send_set(4'($urandom), pick_level(), pick_level());
                11, 12, 13, 14: send_get(4'($urandom));
                15, 16, 17: send_byte(8'($urandom));
                18: send_byte(8'($urandom_range(128, 255)));
                default: send_item(REQ_UNUSED, 8'($urandom), 4'($urandom),
                                   7'($urandom), 7'($urandom));
            endcase
        end
        idle_on = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("midi_channel_volume_tracker_tb: PASS");
        end else begin
            $display("midi_channel_volume_tracker_tb: FAIL");
        end
        $finish;
    end

endmodule
